// ===== rtl/core/lzss_pkg.sv =====
package lzss_pkg;

  // Bits in one literal and in one input word
  localparam int LITERAL_BITS = 8;
  // Shortest match; a length field of zero copies this many bytes
  localparam int MIN_MATCH = 3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic clear_step;  // zero one window entry
    logic load_byte;   // take an input word into the bit reader
    logic take_bit;    // feed one bit to the token decoder
    logic copy_read;   // read one match byte from the window
    logic copy_write;  // store and emit the match byte just read
  } lzss_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clear_last;   // clearing pass is on its final entry
    logic slot_free;    // output register can take a new word
    logic done;         // end token seen, later input is dropped
    logic end_tok;      // the current bit completes the end token
    logic copy_go;      // the current bit completes a match token
    logic more_after;   // input bits remain after the current one
    logic more_now;     // input bits remain at this point
    logic copy_last;    // the byte being copied is the final one
  } lzss_status_t;

endpackage

// ===== rtl/core/lzss_datapath.sv =====
module lzss_datapath
  import lzss_pkg::*;
#(
  parameter int WINDOW_DEPTH = 8192,
  parameter int LENGTH_BITS  = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  lzss_cmd_t    cmd,
  output lzss_status_t status,
  input  logic [7:0]   in_data,
  input  logic         in_last,
  input  logic         out_ready,
  output logic         out_valid,
  output logic [7:0]   out_data,
  output logic [1:0]   out_flags
);

  localparam int OB   = $clog2(WINDOW_DEPTH);
  localparam int AW   = OB + LENGTH_BITS;
  localparam int MAXB = (OB > LITERAL_BITS) ?
                        ((OB > LENGTH_BITS) ? OB : LENGTH_BITS) :
                        ((LITERAL_BITS > LENGTH_BITS) ? LITERAL_BITS : LENGTH_BITS);
  localparam int BRW  = $clog2(MAXB + 1);
  localparam int CNW  = LENGTH_BITS + 1;
  localparam int BLW  = $clog2(LITERAL_BITS + 1);

  localparam logic [1:0] PH_FLAG = 2'd0;
  localparam logic [1:0] PH_LIT  = 2'd1;
  localparam logic [1:0] PH_OFF  = 2'd2;
  localparam logic [1:0] PH_LEN  = 2'd3;

  localparam logic [OB-1:0] LAST_ADDR = OB'(WINDOW_DEPTH - 1);
  localparam logic [OB-1:0] START_POS = OB'(1);

  // History window
  logic [7:0]    mem [WINDOW_DEPTH];
  logic [7:0]    ram_q;
  logic          we;
  logic [OB-1:0] waddr;
  logic [7:0]    wdata;

  // Bit reader and token decoder
  logic [7:0]     shreg;
  logic [BLW-1:0] bits_left;
  logic           byte_last;
  logic [1:0]     phase;
  logic [BRW-1:0] brem;
  logic [AW-1:0]  acc;
  logic           done;

  // Window pointers and copy counter
  logic [OB-1:0]  wp;
  logic [OB-1:0]  rd_addr;
  logic [CNW-1:0] copy_cnt;
  logic [OB-1:0]  clr_cnt;

  // Output register
  logic       out_valid_r;
  logic [7:0] out_data_r;
  logic [1:0] out_flags_r;

  logic          bit_val;
  logic [AW-1:0] acc_new;
  logic          fin;
  logic          lit_done;
  logic [OB-1:0] pos;
  logic [LENGTH_BITS-1:0] len;
  logic [OB-1:0] pos_wrapped;
  logic [OB-1:0] wp_inc;
  logic [OB-1:0] rd_inc;

  // Decode the current bit
  always_comb begin
    bit_val     = (bits_left != '0) ? shreg[7] : 1'b0;
    acc_new     = {acc[AW-2:0], bit_val};
    fin         = (phase != PH_FLAG) && (brem == BRW'(1));
    lit_done    = fin && (phase == PH_LIT);
    pos         = acc_new[AW-1:LENGTH_BITS];
    len         = acc_new[LENGTH_BITS-1:0];
    pos_wrapped = ({1'b0, pos} >= (OB+1)'(WINDOW_DEPTH)) ?
                  OB'({1'b0, pos} - (OB+1)'(WINDOW_DEPTH)) : pos;
    wp_inc      = (wp == LAST_ADDR) ? '0 : wp + OB'(1);
    rd_inc      = (rd_addr == LAST_ADDR) ? '0 : rd_addr + OB'(1);
  end

  always_comb begin
    status.clear_last = (clr_cnt == LAST_ADDR);
    status.slot_free  = !out_valid_r || out_ready;
    status.done       = done;
    status.end_tok    = fin && (phase == PH_OFF) && (acc_new[OB-1:0] == '0);
    status.copy_go    = fin && (phase == PH_LEN);
    status.more_after = (bits_left > BLW'(1)) || byte_last;
    status.more_now   = (bits_left != '0) || byte_last;
    status.copy_last  = (copy_cnt == '0);
  end

  // Select the window write
  always_comb begin
    we    = 1'b0;
    waddr = wp;
    wdata = ram_q;
    if (cmd.clear_step) begin
      we    = 1'b1;
      waddr = clr_cnt;
      wdata = 8'h00;
    end else if (cmd.take_bit && lit_done) begin
      we    = 1'b1;
      wdata = acc_new[7:0];
    end else if (cmd.copy_write) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.copy_read) begin
      ram_q <= mem[rd_addr];
    end
  end

  // Advance the bit reader, decoder and pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      bits_left <= '0;
      byte_last <= 1'b0;
      phase     <= PH_FLAG;
      brem      <= '0;
      acc       <= '0;
      done      <= 1'b0;
      wp        <= START_POS;
      clr_cnt   <= '0;
    end else begin
      if (cmd.clear_step) begin
        clr_cnt <= clr_cnt + OB'(1);
      end
      if (cmd.load_byte) begin
        shreg     <= in_data;
        bits_left <= BLW'(LITERAL_BITS);
        byte_last <= in_last;
      end
      if (cmd.take_bit) begin
        // drop the rest of the input once the end token completes
        if (status.end_tok) begin
          bits_left <= '0;
          byte_last <= 1'b0;
        end else if (bits_left != '0) begin
          shreg     <= {shreg[6:0], 1'b0};
          bits_left <= bits_left - BLW'(1);
        end
        if (phase == PH_FLAG) begin
          acc <= '0;
          if (bit_val) begin
            phase <= PH_LIT;
            brem  <= BRW'(LITERAL_BITS);
          end else begin
            phase <= PH_OFF;
            brem  <= BRW'(OB);
          end
        end else begin
          acc <= acc_new;
          if (!fin) begin
            brem <= brem - BRW'(1);
          end else begin
            case (phase)
              PH_LIT: begin
                phase <= PH_FLAG;
                wp    <= wp_inc;
              end
              PH_OFF: begin
                if (acc_new[OB-1:0] == '0) begin
                  phase <= PH_FLAG;
                  done  <= 1'b1;
                  wp    <= START_POS;
                end else begin
                  phase <= PH_LEN;
                  brem  <= BRW'(LENGTH_BITS);
                end
              end
              PH_LEN: begin
                phase    <= PH_FLAG;
                rd_addr  <= pos_wrapped;
                copy_cnt <= CNW'(len) + CNW'(MIN_MATCH - 1);
              end
              default: begin
                phase <= PH_FLAG;
              end
            endcase
          end
        end
      end
      if (cmd.copy_write) begin
        wp       <= wp_inc;
        rd_addr  <= rd_inc;
        copy_cnt <= copy_cnt - CNW'(1);
      end
    end
  end

  // Load or drain the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_r <= 1'b0;
    end else if (cmd.take_bit && lit_done) begin
      out_valid_r <= 1'b1;
      out_data_r  <= acc_new[7:0];
      out_flags_r <= 2'b01;
    end else if (cmd.take_bit && status.end_tok) begin
      out_valid_r <= 1'b1;
      out_data_r  <= 8'h00;
      out_flags_r <= 2'b10;
    end else if (cmd.copy_write) begin
      out_valid_r <= 1'b1;
      out_data_r  <= ram_q;
      out_flags_r <= 2'b01;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_flags = out_flags_r;

endmodule

// ===== rtl/core/lzss_controller.sv =====
module lzss_controller
  import lzss_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  lzss_status_t status,
  input  logic         in_valid,
  output logic         in_ready,
  output lzss_cmd_t    cmd
);

  localparam logic [2:0] ST_CLEAR   = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_BITS    = 3'd2;
  localparam logic [2:0] ST_COPY_RD = 3'd3;
  localparam logic [2:0] ST_COPY_WR = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  // Sequence the commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && !status.done) begin
          cmd.load_byte = 1'b1;
          state_next    = ST_BITS;
        end
      end
      ST_BITS: begin
        if (status.slot_free) begin
          cmd.take_bit = 1'b1;
          if (status.end_tok) begin
            state_next = ST_IDLE;
          end else if (status.copy_go) begin
            state_next = ST_COPY_RD;
          end else if (!status.more_after) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_COPY_RD: begin
        cmd.copy_read = 1'b1;
        state_next    = ST_COPY_WR;
      end
      ST_COPY_WR: begin
        if (status.slot_free) begin
          cmd.copy_write = 1'b1;
          if (!status.copy_last) begin
            state_next = ST_COPY_RD;
          end else if (status.more_now) begin
            state_next = ST_BITS;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/core/lzss_bitstream_decompressor.sv =====
// LZSS decompressor with a WINDOW_DEPTH-byte history window. Compressed
// words enter on the slave stream and are read MSB first as one bit
// stream: a 1 flag is followed by an 8-bit literal, a 0 flag by an
// absolute window position and a LENGTH_BITS length, which copies
// length+3 bytes from the window. A position of zero ends the stream and
// yields one word with the end flag set; words after that are accepted
// and dropped until reset. The bit reader takes the input bits one at a
// time, waiting while the output register is full, and each match byte
// is handled as a window read, then the write-back and output load,
// since an overlapping copy may read the byte it has just written. After
// the word marked tlast, zero bits are fed until the end token. After
// reset the window is cleared one entry per cycle, so no word is accepted
// until the clearing pass is over. The output register lets a result
// wait while the next compressed word is accepted.
module lzss_bitstream_decompressor
  import lzss_pkg::*;
#(
  parameter int WINDOW_DEPTH = 8192,
  parameter int LENGTH_BITS  = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,   // last_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic [1:0] m_axis_tuser    // [0] out_valid, [1] stream_end
);

  lzss_cmd_t    cmd;
  lzss_status_t status;

  lzss_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .status   (status),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .cmd      (cmd)
  );

  lzss_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .LENGTH_BITS  (LENGTH_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (s_axis_tdata),
    .in_last   (s_axis_tlast),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata),
    .out_flags (m_axis_tuser)
  );

endmodule
